/* sv/dual_quaternion_point_transform_macros.svh */
// assertion macros shared by the rigid transform block
// no dependencies; included by the modules that carry checks
`ifndef DUAL_QUATERNION_POINT_TRANSFORM_MACROS_SVH
`define DUAL_QUATERNION_POINT_TRANSFORM_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define DQPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition in one cycle implies outcome in the next
`define DQPT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define DQPT_ASSERT(lbl, prop, msg)
`define DQPT_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

/* sv/dqpt_pkg.sv */
// types, widths and constants of the rigid transform block
// no dependencies; used by every module of the block
package dqpt_pkg;

  localparam int ROT_W   = 18;  // Q2.16 real part
  localparam int COORD_W = 32;  // Q16.16 dual part and coordinates
  localparam int HALF_W  = 16;  // coordinate split point
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  localparam int RPROD_W = 2 * ROT_W;              // rotation products
  localparam int M_W     = RPROD_W + 2;            // matrix entries, |m| <= 2^36
  localparam int TPROD_W = ROT_W + COORD_W;        // translation products
  localparam int TR_W    = TPROD_W + 6;            // translation sums
  localparam int PROD_W  = M_W + HALF_W + 2;       // matrix times coordinate half
  localparam int SUM_W   = PROD_W + 2;             // accumulated rows
  localparam int RES_W   = SUM_W - HALF_W;         // after the final rounding shift

  localparam logic signed [ROT_W-1:0] ROT_W_RESET = ROT_W'(65536);
  localparam logic signed [SUM_W-1:0] ROUND_HALF  = SUM_W'(32768);
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_W  = 4'd0,
    REG_ROT_X  = 4'd1,
    REG_ROT_Y  = 4'd2,
    REG_ROT_Z  = 4'd3,
    REG_DUAL_W = 4'd4,
    REG_DUAL_X = 4'd5,
    REG_DUAL_Y = 4'd6,
    REG_DUAL_Z = 4'd7
  } cfg_reg_e;

  typedef enum logic {
    OP_POINT  = 1'b0,
    OP_VECTOR = 1'b1
  } op_e;

  typedef logic signed [M_W-1:0]    mat_w_t;
  typedef logic signed [TR_W-1:0]   tr_w_t;
  typedef logic signed [PROD_W-1:0] prod_w_t;
  typedef logic signed [SUM_W-1:0]  sum_w_t;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      saturated;
  } out_item_t;

  // rotation matrix (row major, scale 2^32) and point translation (scale 2^32)
  typedef struct packed {
    mat_w_t [8:0] m;
    tr_w_t  [2:0] tr;
  } coef_t;

  typedef struct packed {
    logic          operation;
    prod_w_t [8:0] p_hi;
    prod_w_t [8:0] p_lo;
  } prod_t;

  typedef struct packed {
    logic         operation;
    sum_w_t [2:0] s_hi;
    sum_w_t [2:0] s_lo;
  } acc_t;

endpackage

/* sv/dqpt_coef.sv */
// configuration registers and the two-stage coefficient pipeline
// depends on dqpt_pkg
module dqpt_coef (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [dqpt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dqpt_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  output dqpt_pkg::coef_t                 coef_o
);
  import dqpt_pkg::*;

  logic signed [ROT_W-1:0]   w_q, x_q, y_q, z_q;
  logic signed [COORD_W-1:0] dw_q, dx_q, dy_q, dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= ROT_W_RESET;
      x_q  <= '0;
      y_q  <= '0;
      z_q  <= '0;
      dw_q <= '0;
      dx_q <= '0;
      dy_q <= '0;
      dz_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROT_W:  w_q  <= cfg_data_i[ROT_W-1:0];
        REG_ROT_X:  x_q  <= cfg_data_i[ROT_W-1:0];
        REG_ROT_Y:  y_q  <= cfg_data_i[ROT_W-1:0];
        REG_ROT_Z:  z_q  <= cfg_data_i[ROT_W-1:0];
        REG_DUAL_W: dw_q <= cfg_data_i[COORD_W-1:0];
        REG_DUAL_X: dx_q <= cfg_data_i[COORD_W-1:0];
        REG_DUAL_Y: dy_q <= cfg_data_i[COORD_W-1:0];
        REG_DUAL_Z: dz_q <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // stage one: all products of the configuration
  logic signed [RPROD_W-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  logic signed [TPROD_W-1:0] wdx_q, wdy_q, wdz_q, dwx_q, dwy_q, dwz_q;
  logic signed [TPROD_W-1:0] ydz_q, zdy_q, zdx_q, xdz_q, xdy_q, ydx_q;

  always_ff @(posedge clk_i) begin
    ww_q  <= w_q * w_q;
    xx_q  <= x_q * x_q;
    yy_q  <= y_q * y_q;
    zz_q  <= z_q * z_q;
    xy_q  <= x_q * y_q;
    wz_q  <= w_q * z_q;
    xz_q  <= x_q * z_q;
    wy_q  <= w_q * y_q;
    yz_q  <= y_q * z_q;
    wx_q  <= w_q * x_q;
    wdx_q <= w_q * dx_q;
    wdy_q <= w_q * dy_q;
    wdz_q <= w_q * dz_q;
    dwx_q <= dw_q * x_q;
    dwy_q <= dw_q * y_q;
    dwz_q <= dw_q * z_q;
    ydz_q <= y_q * dz_q;
    zdy_q <= z_q * dy_q;
    zdx_q <= z_q * dx_q;
    xdz_q <= x_q * dz_q;
    xdy_q <= x_q * dy_q;
    ydx_q <= y_q * dx_q;
  end

  // stage two: matrix entries and translation
  coef_t coef_d, coef_q;

  always_comb begin
    coef_d.m[0] = M_W'(ww_q) + M_W'(xx_q) - M_W'(yy_q) - M_W'(zz_q);
    coef_d.m[1] = (M_W'(xy_q) - M_W'(wz_q)) <<< 1;
    coef_d.m[2] = (M_W'(xz_q) + M_W'(wy_q)) <<< 1;
    coef_d.m[3] = (M_W'(xy_q) + M_W'(wz_q)) <<< 1;
    coef_d.m[4] = M_W'(ww_q) - M_W'(xx_q) + M_W'(yy_q) - M_W'(zz_q);
    coef_d.m[5] = (M_W'(yz_q) - M_W'(wx_q)) <<< 1;
    coef_d.m[6] = (M_W'(xz_q) - M_W'(wy_q)) <<< 1;
    coef_d.m[7] = (M_W'(yz_q) + M_W'(wx_q)) <<< 1;
    coef_d.m[8] = M_W'(ww_q) - M_W'(xx_q) - M_W'(yy_q) + M_W'(zz_q);
    coef_d.tr[0] = (TR_W'(wdx_q) - TR_W'(dwx_q) + TR_W'(ydz_q) - TR_W'(zdy_q)) <<< 1;
    coef_d.tr[1] = (TR_W'(wdy_q) - TR_W'(dwy_q) + TR_W'(zdx_q) - TR_W'(xdz_q)) <<< 1;
    coef_d.tr[2] = (TR_W'(wdz_q) - TR_W'(dwz_q) + TR_W'(xdy_q) - TR_W'(ydx_q)) <<< 1;
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign coef_o = coef_q;

endmodule

/* sv/dqpt_prod.sv */
// multiply stage: each matrix entry times both halves of a coordinate
// depends on dqpt_pkg
module dqpt_prod (
  input  logic               clk_i,
  input  logic               en_i,
  input  dqpt_pkg::in_item_t item_i,
  input  dqpt_pkg::coef_t    coef_i,
  output dqpt_pkg::prod_t    prod_o
);
  import dqpt_pkg::*;

  prod_t prod_d, prod_q;

  always_comb begin
    logic signed [COORD_W-1:0]  p [3];
    logic signed [HALF_W-1:0]   hi;
    logic signed [HALF_W:0]     lo;
    logic signed [M_W+HALF_W-1:0] mh;
    logic signed [M_W+HALF_W:0]   ml;
    p[0] = item_i.in_x;
    p[1] = item_i.in_y;
    p[2] = item_i.in_z;
    prod_d.operation = item_i.operation;
    for (int k = 0; k < 9; k++) begin
      // signed high half, unsigned low half of the column coordinate
      hi = p[k % 3][COORD_W-1:HALF_W];
      lo = {1'b0, p[k % 3][HALF_W-1:0]};
      mh = $signed(coef_i.m[k]) * hi;
      ml = $signed(coef_i.m[k]) * lo;
      prod_d.p_hi[k] = PROD_W'(mh);
      prod_d.p_lo[k] = PROD_W'(ml);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

/* sv/dqpt_acc.sv */
// row accumulation stage: sums the high and low partial products of each row
// depends on dqpt_pkg
module dqpt_acc (
  input  logic            clk_i,
  input  logic            en_i,
  input  dqpt_pkg::prod_t prod_i,
  output dqpt_pkg::acc_t  acc_o
);
  import dqpt_pkg::*;

  acc_t acc_d, acc_q;

  always_comb begin
    acc_d.operation = prod_i.operation;
    for (int i = 0; i < 3; i++) begin
      acc_d.s_hi[i] = SUM_W'($signed(prod_i.p_hi[3*i])) + SUM_W'($signed(prod_i.p_hi[3*i+1]))
                    + SUM_W'($signed(prod_i.p_hi[3*i+2]));
      acc_d.s_lo[i] = SUM_W'($signed(prod_i.p_lo[3*i])) + SUM_W'($signed(prod_i.p_lo[3*i+1]))
                    + SUM_W'($signed(prod_i.p_lo[3*i+2]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

/* sv/dqpt_out.sv */
// final stage: adds translation to points, rounds to Q16.16 and saturates
// depends on dqpt_pkg
module dqpt_out (
  input  logic                clk_i,
  input  logic                en_i,
  input  dqpt_pkg::acc_t      acc_i,
  input  dqpt_pkg::coef_t     coef_i,
  output dqpt_pkg::out_item_t item_o
);
  import dqpt_pkg::*;

  out_item_t item_d, item_q;

  always_comb begin
    sum_w_t                    s;
    sum_w_t                    t;
    logic signed [RES_W-1:0]   r;
    logic signed [COORD_W-1:0] c [3];
    logic                      clip;
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      t = (acc_i.operation == OP_VECTOR) ? '0 : SUM_W'($signed(coef_i.tr[i]));
      // low sum is floored by 2^16 before joining, then round half up
      s = $signed(acc_i.s_hi[i]) + ($signed(acc_i.s_lo[i]) >>> HALF_W) + t + ROUND_HALF;
      r = s[SUM_W-1:HALF_W];
      if (r[RES_W-1:COORD_W-1] == '0 || r[RES_W-1:COORD_W-1] == '1) begin
        c[i] = r[COORD_W-1:0];
      end else begin
        c[i] = r[RES_W-1] ? COORD_MIN : COORD_MAX;
        clip = 1'b1;
      end
    end
    item_d.out_x     = c[0];
    item_d.out_y     = c[1];
    item_d.out_z     = c[2];
    item_d.saturated = clip;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

/* sv/dual_quaternion_point_transform.sv */
// top level of the dual quaternion rigid transform of points and vectors
// depends on dqpt_pkg, dqpt_coef, dqpt_prod, dqpt_acc, dqpt_out and the macro header
//
// usage:
// - cfg channel: cfg_valid_i with cfg_index_i 0..7 (rot_w/x/y/z, dual_w/x/y/z) and
//   cfg_data_i; cfg_ready_o is always high, indexes above 7 are dropped
// - write configuration only while the block holds no request; a request may follow
//   in the cycle after the last write (the coefficient pipeline is two stages deep)
// - in channel: a request is taken when in_valid_i is high and in_stall_o is low
// - out channel: a result is taken when out_valid_o is high and out_stall_i is low
// - pipeline: five register stages (input, align, multiply, row sum, round/saturate)
// - throughput: one request per cycle, set by the fully pipelined multiply stage,
//   as long as the receiver does not stall
// - each stage holds a valid bit; a stage loads when it is empty or its successor
//   moves on, so bubbles close up while the receiver stalls and in_stall_o only rises
//   when every stage holds a result
// - reset: pipeline emptied, configuration back to identity rotation, no translation
module dual_quaternion_point_transform (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dqpt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dqpt_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  dqpt_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output dqpt_pkg::out_item_t             out_item_o
);
  import dqpt_pkg::*;
  `include "dual_quaternion_point_transform_macros.svh"

  localparam int NSTG = 5;

  // coefficients from cfg, kept stable while requests are in flight by the user alone
  coef_t coef;

  assign cfg_ready_o = 1'b1;

  dqpt_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  // stage valid bits and load enables
  logic [NSTG-1:0] vld_d, vld_q;
  logic [NSTG-1:0] load;

  always_comb begin
    load[NSTG-1] = !vld_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG-2; k >= 0; k--) begin
      load[k] = !vld_q[k] || load[k+1];
    end
    vld_d[0] = load[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_d[k] = load[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !load[0];
  assign out_valid_o = vld_q[NSTG-1];

  // input register and an align stage that waits out the coefficient pipeline
  in_item_t s1_q, s2_q;

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      s1_q <= in_item_i;
    end
    if (load[1]) begin
      s2_q <= s1_q;
    end
  end

  prod_t prod;
  acc_t  acc;

  dqpt_prod u_prod (
    .clk_i  (clk_i),
    .en_i   (load[2]),
    .item_i (s2_q),
    .coef_i (coef),
    .prod_o (prod)
  );

  dqpt_acc u_acc (
    .clk_i  (clk_i),
    .en_i   (load[3]),
    .prod_i (prod),
    .acc_o  (acc)
  );

  dqpt_out u_out (
    .clk_i  (clk_i),
    .en_i   (load[4]),
    .acc_i  (acc),
    .coef_i (coef),
    .item_o (out_item_o)
  );

  // flag raised while the result is saturated but no coordinate sits at a bound
  logic clip_no_bound;

  assign clip_no_bound = out_item_o.saturated &&
                         out_item_o.out_x != COORD_MAX && out_item_o.out_x != COORD_MIN &&
                         out_item_o.out_y != COORD_MAX && out_item_o.out_y != COORD_MIN &&
                         out_item_o.out_z != COORD_MAX && out_item_o.out_z != COORD_MIN;

  // a taken request always lands in the input stage
  `DQPT_ASSERT_NEXT(a_take_lands, in_valid_i && !in_stall_o, vld_q[0], "taken request lost")
  // a row sum moves into an empty output register without delay
  `DQPT_ASSERT_NEXT(a_out_fill, vld_q[3] && !vld_q[4], vld_q[4], "output stage not filled")
  // a clipped result has at least one coordinate at a bound
  `DQPT_ASSERT(a_sat_bound, out_valid_o |-> !clip_no_bound, "saturated result off the bounds")

endmodule
